// File: hdl/dsvm_pkg.sv
package dsvm_pkg;

  localparam int MAX_VOICES       = 16;
  localparam int VIDX_W           = $clog2(MAX_VOICES);
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SIDX_W           = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int FRAC_W           = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_W           = 15;
  localparam int LEVEL_W          = 16;
  localparam int SUM_W            = 32 + VIDX_W + 1;
  localparam int CHORD_VOICES     = 4;
  localparam int CHORD_W          = $clog2(CHORD_VOICES);

  localparam longint unsigned SAMPLE_RATE_CENTI = 64'd4410000;

  localparam logic [LEVEL_W-1:0] LEVEL_RESOLVE = 16'd16384;
  localparam logic [LEVEL_W-1:0] LEVEL_PLAIN   = 16'd9830;
  localparam logic [LEVEL_W-1:0] LEVEL_CHORD   = 16'd19661;
  localparam logic [LEVEL_W-1:0] LEVEL_FREE    = 16'd66;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_NOTE  = 2'd1,
    FUNC_CHORD = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_RESOLVE = 2'd1,
    KIND_CHORD   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_CHORD,
    S_WALK,
    S_DRAIN1,
    S_DRAIN2,
    S_SCALE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic fill_step;
    logic start_note;
    logic start_chord;
    logic chord_clear;
    logic walk_step;
    logic clear_sum;
    logic scale;
    logic out_load;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic fill_done;
    logic walk_last;
    logic chord_last;
    logic out_busy;
    logic enabled;
  } sts_t;

  typedef logic [31:0] step_tab15_t [15];
  typedef logic [31:0] step_tab4_t [CHORD_VOICES];
  typedef logic [15:0] decay_tab_t [4];
  typedef logic [SINE_W-1:0] sine_tab_t [SINE_TABLE_DEPTH+1];

  function automatic logic [31:0] step_for(input longint unsigned centihz);
    longint unsigned r;
    r = ((centihz << 32) + SAMPLE_RATE_CENTI / 2) / SAMPLE_RATE_CENTI;
    return r[31:0];
  endfunction

  function automatic step_tab15_t build_scale();
    step_tab15_t t;
    t[0]  = step_for(13081); t[1]  = step_for(14683); t[2]  = step_for(16481);
    t[3]  = step_for(19600); t[4]  = step_for(22000); t[5]  = step_for(26163);
    t[6]  = step_for(29366); t[7]  = step_for(32963); t[8]  = step_for(39200);
    t[9]  = step_for(44000); t[10] = step_for(52325); t[11] = step_for(58733);
    t[12] = step_for(65925); t[13] = step_for(78399); t[14] = step_for(88000);
    return t;
  endfunction

  function automatic step_tab4_t build_chord();
    step_tab4_t t;
    t[0] = step_for(52325); t[1] = step_for(65925);
    t[2] = step_for(78399); t[3] = step_for(104650);
    return t;
  endfunction

  function automatic longint unsigned mul_q30(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint unsigned t, u, p, s;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      t = (longint'(i) << 30) / SINE_TABLE_DEPTH;
      u = mul_q30(t, t);
      p = 64'd5026993 - mul_q30(u, 64'd172271);
      p = 64'd85569306 - mul_q30(u, p);
      p = 64'd693598668 - mul_q30(u, p);
      p = 64'd1686629713 - mul_q30(u, p);
      s = (mul_q30(t, p) + 64'd16384) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      tab[i] = s[SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam step_tab15_t SCALE_STEP = build_scale();
  localparam step_tab4_t  CHORD_STEP = build_chord();
  localparam decay_tab_t  DECAY_Q16  = '{16'd64553, 16'd65012, 16'd65339, 16'd0};
  localparam sine_tab_t   SINE_ROM   = build_sine();

endpackage

// File: hdl/dsvm_ram.sv
module dsvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/dsvm_ctrl.sv
module dsvm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic [1:0]    s_tuser,
  input  dsvm_pkg::sts_t sts,
  output dsvm_pkg::cmd_t cmd
);
  import dsvm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.chord_clear = 1'b1;
        if (s_tvalid) begin
          case (s_tuser)
            FUNC_TICK: begin
              cmd.clear_sum = 1'b1;
              state_next = S_WALK;
            end
            FUNC_NOTE: cmd.start_note = sts.enabled;
            FUNC_CHORD: if (sts.enabled) state_next = S_CHORD;
            default: ;
          endcase
        end
      end
      S_CHORD: begin
        cmd.start_chord = 1'b1;
        if (sts.chord_last) state_next = S_IDLE;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) state_next = S_DRAIN1;
      end
      S_DRAIN1: state_next = S_DRAIN2;
      S_DRAIN2: state_next = S_SCALE;
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hdl/dsvm_dpath.sv
module dsvm_dpath (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic [15:0]    s_tdata,
  input  logic           m_tready,
  output logic           m_tvalid,
  output logic [15:0]    m_tdata,
  input  dsvm_pkg::cmd_t cmd,
  output dsvm_pkg::sts_t sts
);
  import dsvm_pkg::*;

  logic                  enabled;
  logic [MAX_VOICES-1:0] vactive;
  logic [31:0]           vphase [MAX_VOICES];
  logic [31:0]           vstep  [MAX_VOICES];
  logic [LEVEL_W-1:0]    vlevel [MAX_VOICES];
  logic [1:0]            vkind  [MAX_VOICES];

  logic [SIDX_W-1:0]  fill_idx;
  logic [VIDX_W-1:0]  vidx;
  logic [CHORD_W-1:0] chord_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg_we) begin
      enabled <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_idx <= '0;
    end else if (cmd.fill_step && !sts.fill_done) begin
      fill_idx <= fill_idx + 1'b1;
    end
  end

  logic [SIDX_W-1:0] raddr;
  logic [SINE_W-1:0] rdata;

  dsvm_ram #(.WIDTH(SINE_W), .DEPTH(SINE_TABLE_DEPTH + 1)) u_sine (
    .clk   (clk),
    .we    (cmd.fill_step),
    .waddr (fill_idx),
    .wdata (SINE_ROM[fill_idx]),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic [9:0]  depth;
  logic        resolve;
  logic [21:0] quot_prod;
  logic [9:0]  quot15;
  logic [13:0] quot_x15;
  logic [3:0]  pitch;

  assign depth   = s_tdata[9:0];
  assign resolve = s_tdata[10];

  // A reciprocal of 15 in Q15 gives the exact quotient over the whole ten-bit range.
  assign quot_prod = depth * 12'd2185;
  assign quot15    = {3'd0, quot_prod[21:15]};
  assign quot_x15  = {4'd0, quot15} * 14'd15;
  assign pitch     = 4'(depth - quot_x15[9:0]);

  logic [VIDX_W-1:0] free_idx;
  logic              free_any;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int v = MAX_VOICES - 1; v >= 0; v--) begin
      if (!vactive[v]) begin
        free_idx = VIDX_W'(v);
        free_any = 1'b1;
      end
    end
  end

  logic               do_start;
  logic [31:0]        new_step;
  logic [LEVEL_W-1:0] new_level;
  logic [1:0]         new_kind;

  always_comb begin
    do_start  = 1'b0;
    new_step  = CHORD_STEP[chord_k];
    new_level = LEVEL_CHORD;
    new_kind  = KIND_CHORD;
    if (cmd.start_note) begin
      do_start  = free_any;
      new_step  = SCALE_STEP[pitch];
      new_level = resolve ? LEVEL_RESOLVE : LEVEL_PLAIN;
      new_kind  = resolve ? KIND_RESOLVE : KIND_PLAIN;
    end else if (cmd.start_chord) begin
      do_start = free_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.chord_clear) begin
      chord_k <= '0;
    end else if (cmd.start_chord) begin
      chord_k <= chord_k + 1'b1;
    end
  end

  logic [31:0]        cur_phase;
  logic [LEVEL_W-1:0] cur_level;
  logic [31:0]        decay_prod;
  logic [LEVEL_W-1:0] decayed;
  logic [FRAC_W-1:0]  frac;
  logic               walk_live;

  assign cur_phase  = vphase[vidx];
  assign cur_level  = vlevel[vidx];
  assign decay_prod = cur_level * DECAY_Q16[vkind[vidx]];
  assign decayed    = decay_prod[31:16];
  assign frac       = cur_phase[29 -: FRAC_W];
  assign raddr      = cur_phase[30] ? SIDX_W'(SINE_TABLE_DEPTH - frac) : SIDX_W'(frac);
  assign walk_live  = cmd.walk_step && vactive[vidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      vidx <= '0;
    end else if (cmd.walk_step) begin
      vidx <= vidx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vactive <= '0;
    end else if (do_start) begin
      vactive[free_idx] <= 1'b1;
    end else if (walk_live && decayed < LEVEL_FREE) begin
      vactive[vidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      vphase[free_idx] <= '0;
      vstep[free_idx]  <= new_step;
      vlevel[free_idx] <= new_level;
      vkind[free_idx]  <= new_kind;
    end else if (walk_live) begin
      vphase[vidx] <= cur_phase + vstep[vidx];
      vlevel[vidx] <= decayed;
    end
  end

  logic                p1_valid, p2_valid;
  logic                p1_neg, p2_neg;
  logic [LEVEL_W-1:0]  p1_level;
  logic [30:0]         p2_prod;
  logic signed [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= walk_live;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_neg   <= cur_phase[31];
    p1_level <= cur_level;
    p2_neg   <= p1_neg;
    p2_prod  <= rdata * p1_level;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_sum) begin
      sum <= '0;
    end else if (p2_valid) begin
      if (p2_neg) begin
        sum <= sum - $signed({{(SUM_W-31){1'b0}}, p2_prod});
      end else begin
        sum <= sum + $signed({{(SUM_W-31){1'b0}}, p2_prod});
      end
    end
  end

  localparam logic signed [SUM_W-1:0] CLIP_HI = SUM_W'(64'sd2147483648);
  localparam logic signed [SUM_W-1:0] CLIP_LO = -CLIP_HI;

  logic signed [32:0] clipped;
  logic signed [48:0] scaled;
  logic signed [48:0] rounded;

  always_comb begin
    if (sum > CLIP_HI) begin
      clipped = 33'sh080000000;
    end else if (sum < CLIP_LO) begin
      clipped = -33'sh080000000;
    end else begin
      clipped = 33'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      scaled <= clipped * 49'sd32767;
    end
  end

  // A negative product is biased so that the shift truncates toward zero.
  assign rounded = scaled[48] ? scaled + 49'sd2147483647 : scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= rounded[46:31];
    end
  end

  assign sts.fill_done  = (fill_idx == SIDX_W'(SINE_TABLE_DEPTH));
  assign sts.walk_last  = (vidx == VIDX_W'(MAX_VOICES - 1));
  assign sts.chord_last = (chord_k == CHORD_W'(CHORD_VOICES - 1));
  assign sts.out_busy   = m_tvalid && !m_tready;
  assign sts.enabled    = enabled;

endmodule

// File: hdl/decaying_sine_voice_mixer_unit.sv
// Channel   Direction  Contents
// s_axis    in         tuser: func; tdata: note_depth, is_resolve
// m_axis    out        tdata: sample, one word per tick
// cfg       in         cfg_we, cfg_wdata: enabled
//
// A tick walks the voice slots one per cycle through the shared sine read and
// multipliers, then goes through S_DRAIN1, S_DRAIN2, S_SCALE and S_OUT to its output word.
// A note starts its voice as it is accepted; a chord then starts one voice per cycle.
// After reset all 1025 sine table entries are written, during which s_tready is low.
// A waiting output word holds the next tick in its final cycle until it is taken.
module decaying_sine_voice_mixer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // note_depth [9:0], is_resolve [10], zero [15:11]
  input  logic [1:0]  s_tuser,   // func [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // sample [15:0]
);
  import dsvm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dsvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsvm_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign s_tready = cmd.in_ready;

endmodule

// File: hdl/dsvm_chk.sv
module dsvm_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import dsvm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata != 16'h8000)
    else $error("sample outside the clipped range");

  a_fill: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input taken before the sine table is filled");

  a_event: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != FUNC_TICK && !m_tvalid |=> !m_tvalid)
    else $error("an event produced an output word");

endmodule

bind decaying_sine_voice_mixer_unit dsvm_chk u_dsvm_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: test/decaying_sine_voice_mixer_unit_tb.sv
module decaying_sine_voice_mixer_unit_tb;
  import dsvm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  decaying_sine_voice_mixer_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  logic            mix_enabled;
  logic            voice_on [MAX_VOICES];
  logic [31:0]     voice_ph [MAX_VOICES];
  logic [31:0]     voice_inc [MAX_VOICES];
  logic [15:0]     voice_lvl [MAX_VOICES];
  logic [1:0]      voice_kind [MAX_VOICES];
  int              quarter_wave [SINE_TABLE_DEPTH+1];
  logic [15:0]     expected_samples [$];
  int              error_count = 0;
  int              idle_cycles = 0;
  bit              quiet_run = 1'b0;
  int              out_stall = 0;

  const int unsigned scale_hz [15] = '{13081, 14683, 16481, 19600, 22000, 26163, 29366,
                                       32963, 39200, 44000, 52325, 58733, 65925, 78399,
                                       88000};
  const int unsigned chord_hz [4] = '{52325, 65925, 78399, 104650};
  const int unsigned decay_mul [4] = '{64553, 65012, 65339, 0};

  function automatic longint unsigned q30(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  task automatic make_quarter_wave();
    longint unsigned x, x2, acc, r;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = 64'(i) << 30;
      x = x / SINE_TABLE_DEPTH;
      x2 = q30(x, x);
      acc = 64'd5026993 - q30(x2, 64'd172271);
      acc = 64'd85569306 - q30(x2, acc);
      acc = 64'd693598668 - q30(x2, acc);
      acc = 64'd1686629713 - q30(x2, acc);
      r = (q30(x, acc) + 64'd16384) >> 15;
      if (r > 64'd32767) r = 64'd32767;
      quarter_wave[i] = int'(r);
    end
  endtask

  function automatic int sine_at(logic [31:0] ph);
    longint unsigned pos;
    int idx;
    pos = {34'd0, ph[29:0]};
    idx = int'((pos * SINE_TABLE_DEPTH) >> 30);
    if (idx > SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH;
    if (ph[30]) idx = SINE_TABLE_DEPTH - idx;
    return ph[31] ? -quarter_wave[idx] : quarter_wave[idx];
  endfunction

  function automatic logic [31:0] phase_inc(int unsigned centihz);
    longint unsigned r;
    r = 64'(centihz) << 32;
    r = (r + 64'd2205000) / 64'd4410000;
    return r[31:0];
  endfunction

  task automatic open_voice(int unsigned centihz, logic [15:0] lvl, logic [1:0] kind);
    for (int v = 0; v < MAX_VOICES; v++) begin
      if (!voice_on[v]) begin
        voice_on[v] = 1'b1;
        voice_ph[v] = '0;
        voice_inc[v] = phase_inc(centihz);
        voice_lvl[v] = lvl;
        voice_kind[v] = kind;
        return;
      end
    end
  endtask

  task automatic mix_tick();
    longint sum, s;
    longint unsigned nl;
    sum = 0;
    for (int v = 0; v < MAX_VOICES; v++) begin
      if (voice_on[v]) begin
        sum += longint'(sine_at(voice_ph[v])) * longint'({48'd0, voice_lvl[v]});
        voice_ph[v] = voice_ph[v] + voice_inc[v];
        nl = {48'd0, voice_lvl[v]};
        nl = (nl * decay_mul[voice_kind[v]]) >> 16;
        voice_lvl[v] = nl[15:0];
        if (nl < 66) voice_on[v] = 1'b0;
      end
    end
    if (sum > 64'sd2147483648) sum = 64'sd2147483648;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    s = (sum * 32767) / 64'sd2147483648;
    expected_samples.insert(expected_samples.size(), s[15:0]);
  endtask

  task automatic predict_item(logic [1:0] func, logic [9:0] depth, logic res);
    if (func == FUNC_TICK) begin
      mix_tick();
    end else if (mix_enabled) begin
      if (func == FUNC_NOTE) begin
        if (res) open_voice(scale_hz[depth % 15], LEVEL_RESOLVE, KIND_RESOLVE);
        else open_voice(scale_hz[depth % 15], LEVEL_PLAIN, KIND_PLAIN);
      end else if (func == FUNC_CHORD) begin
        for (int k = 0; k < 4; k++) open_voice(chord_hz[k], LEVEL_CHORD, KIND_CHORD);
      end
    end
  endtask

  task automatic send_word(logic [1:0] func, logic [9:0] depth, logic res);
    int gap;
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {5'd0, res, depth};
    do @(posedge clk); while (!s_tready);
    predict_item(func, depth, res);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enabled(logic val);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    mix_enabled = val;
  endtask

  task automatic test_disabled_events();
    send_word(FUNC_NOTE, 10'd7, 1'b1);
    send_word(FUNC_CHORD, 10'd0, 1'b0);
    send_word(2'd3, 10'h3FF, 1'b1);
    send_word(FUNC_TICK, 10'h3FF, 1'b1);
    send_word(FUNC_TICK, 10'd0, 1'b0);
  endtask

  task automatic test_note_edges();
    write_enabled(1'b1);
    send_word(FUNC_NOTE, 10'd0, 1'b0);
    send_word(FUNC_NOTE, 10'd14, 1'b1);
    send_word(FUNC_NOTE, 10'd15, 1'b0);
    send_word(FUNC_NOTE, 10'h3FF, 1'b1);
    send_word(2'd3, 10'h155, 1'b0);
    repeat (4) send_word(FUNC_TICK, 10'h2AA, 1'b0);
  endtask

  task automatic test_full_table();
    repeat (4) send_word(FUNC_CHORD, 10'h3FF, 1'b1);
    send_word(FUNC_NOTE, 10'd3, 1'b1);
    repeat (6) send_word(FUNC_TICK, 10'd0, 1'b0);
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) send_word(FUNC_TICK, 10'($urandom), 1'($urandom));
    else if (pick < 80) send_word(FUNC_NOTE, 10'($urandom), 1'($urandom));
    else if (pick < 90) send_word(FUNC_CHORD, 10'($urandom), 1'($urandom));
    else send_word(2'd3, 10'($urandom), 1'($urandom));
  endtask

  task automatic test_random_mix();
    repeat (250) random_word();
    write_enabled(1'b0);
    repeat (60) random_word();
    write_enabled(1'b1);
    repeat (200) random_word();
  endtask

  task automatic test_no_idle();
    quiet_run = 1'b1;
    repeat (90) random_word();
  endtask

  always @(posedge clk) begin
    if (quiet_run) begin
      m_tready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      m_tready <= (out_stall == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= $urandom_range(1, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        $error("sample: no word expected, actual %0d", $signed(m_tdata));
        error_count++;
      end else begin
        if (m_tdata !== expected_samples[0]) begin
          $error("sample: expected %0d, actual %0d", $signed(expected_samples[0]),
                 $signed(m_tdata));
          error_count++;
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("decaying_sine_voice_mixer_unit_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mix_enabled = 1'b0;
    for (int v = 0; v < MAX_VOICES; v++) voice_on[v] = 1'b0;
    make_quarter_wave();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_disabled_events();
    test_note_edges();
    test_full_table();
    test_random_mix();
    test_no_idle();
    settle();
    if (error_count == 0) begin
      $display("decaying_sine_voice_mixer_unit_tb passed");
    end else begin
      $display("decaying_sine_voice_mixer_unit_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/dsvm_pkg.sv
hdl/dsvm_ram.sv
hdl/dsvm_ctrl.sv
hdl/dsvm_dpath.sv
hdl/decaying_sine_voice_mixer_unit.sv
hdl/dsvm_chk.sv
test/decaying_sine_voice_mixer_unit_tb.sv
